/* src/ptsd_pkg.sv */
// package: shared widths, register indexes and flag types for the segment distance block
package ptsd_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int IN_W = 32;
   localparam int OUT_W = 32;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_X = 3'd0,
      CSR_START_Y = 3'd1,
      CSR_START_W = 3'd2,
      CSR_END_X   = 3'd3,
      CSR_END_Y   = 3'd4,
      CSR_END_W   = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic at_inf;
      logic outside;
      logic s_zero;
   } flags_type;

endpackage

/* src/ptsd_div.sv */
// pipelined restoring divider, one quotient bit per stage, with a carried tag
module ptsd_div import ptsd_pkg::*; #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   input  logic [TAG_W-1:0] tag_in,
   output logic             out_valid,
   output logic [NUM_W-1:0] quo,
   output logic [TAG_W-1:0] tag_out
);

   logic [NUM_W-1:0] vld_ff;
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [DEN_W-1:0] rem_in [NUM_W];
   logic [NUM_W-1:0] nq_ff  [NUM_W];
   logic [NUM_W-1:0] nq_in  [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];
   logic [TAG_W-1:0] tag_ff [NUM_W];

   always_comb begin
      logic [DEN_W-1:0] rp;
      logic [DEN_W-1:0] dp;
      logic [NUM_W-1:0] np;
      logic [DEN_W:0]   t;
      logic             qb;
      for (int i = 0; i < NUM_W; i++) begin
         if (i == 0) begin
            rp = '0;
            np = num;
            dp = den;
         end else begin
            rp = rem_ff[i-1];
            np = nq_ff[i-1];
            dp = den_ff[i-1];
         end
         t = {rp, np[NUM_W-1]};
         qb = (t >= {1'b0, dp});
         if (qb) begin
            rem_in[i] = DEN_W'(t - {1'b0, dp});
         end else begin
            rem_in[i] = t[DEN_W-1:0];
         end
         nq_in[i] = {np[NUM_W-2:0], qb};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NUM_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_W; i++) begin
            rem_ff[i] <= rem_in[i];
            nq_ff[i]  <= nq_in[i];
            if (i == 0) begin
               den_ff[i] <= den;
               tag_ff[i] <= tag_in;
            end else begin
               den_ff[i] <= den_ff[i-1];
               tag_ff[i] <= tag_ff[i-1];
            end
         end
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign quo = nq_ff[NUM_W-1];
   assign tag_out = tag_ff[NUM_W-1];

endmodule

/* src/ptsd_sqrt.sv */
// pipelined digit-by-digit integer square root, one root bit per stage
module ptsd_sqrt import ptsd_pkg::*; #(
   parameter int X_W = 69,
   parameter int TAG_W = 1,
   localparam int R_W = (X_W + 1) / 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [X_W-1:0]   x,
   input  logic [TAG_W-1:0] tag_in,
   output logic             out_valid,
   output logic [R_W-1:0]   root,
   output logic [TAG_W-1:0] tag_out
);

   logic [R_W-1:0]   vld_ff;
   logic [R_W:0]     rem_ff  [R_W];
   logic [R_W:0]     rem_in  [R_W];
   logic [R_W-1:0]   root_ff [R_W];
   logic [R_W-1:0]   root_in [R_W];
   logic [2*R_W-1:0] xs_ff   [R_W];
   logic [2*R_W-1:0] xs_in   [R_W];
   logic [TAG_W-1:0] tag_ff  [R_W];

   always_comb begin
      logic [R_W:0]     rp;
      logic [R_W-1:0]   op;
      logic [2*R_W-1:0] xp;
      logic [R_W+2:0]   t;
      logic [R_W+2:0]   trial;
      for (int i = 0; i < R_W; i++) begin
         if (i == 0) begin
            rp = '0;
            op = '0;
            xp = (2*R_W)'(x);
         end else begin
            rp = rem_ff[i-1];
            op = root_ff[i-1];
            xp = xs_ff[i-1];
         end
         t = {rp, xp[2*R_W-1 -: 2]};
         trial = (R_W+3)'({op, 2'b01});
         if (t >= trial) begin
            rem_in[i]  = (R_W+1)'(t - trial);
            root_in[i] = {op[R_W-2:0], 1'b1};
         end else begin
            rem_in[i]  = t[R_W:0];
            root_in[i] = {op[R_W-2:0], 1'b0};
         end
         xs_in[i] = {xp[2*R_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[R_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < R_W; i++) begin
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            xs_ff[i]   <= xs_in[i];
            if (i == 0) begin
               tag_ff[i] <= tag_in;
            end else begin
               tag_ff[i] <= tag_ff[i-1];
            end
         end
      end
   end

   assign out_valid = vld_ff[R_W-1];
   assign root = root_ff[R_W-1];
   assign tag_out = tag_ff[R_W-1];

endmodule

/* src/ptsd_dehom.sv */
// homogeneous to plain coordinate lane: magnitude divide by w, sign and saturation
module ptsd_dehom import ptsd_pkg::*; #(
   parameter int CW = 32,
   parameter int FRAC_BITS = 16,
   parameter int TAG_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [IN_W-1:0] h,
   input  logic signed [IN_W-1:0] w,
   input  logic [TAG_W-1:0]     tag_in,
   output logic                 out_valid,
   output logic signed [CW-1:0] coord,
   output logic [TAG_W-1:0]     tag_out
);

   localparam int Q_W = IN_W + FRAC_BITS;
   localparam int C_W = (Q_W > CW ? Q_W : CW) + 1;
   localparam logic [C_W-1:0] LIM_NEG = C_W'(1) << (CW - 1);
   localparam logic [C_W-1:0] LIM_POS = LIM_NEG - C_W'(1);

   logic [IN_W-1:0]    mh;
   logic [IN_W-1:0]    mw;
   logic               w_zero;
   logic               neg;
   logic [Q_W-1:0]     quo;
   logic [TAG_W+2:0]   dtag;
   logic [C_W-1:0]     qe;
   logic [C_W-1:0]     qs;

   assign mh = h[IN_W-1] ? IN_W'(-h) : IN_W'(h);
   assign mw = w[IN_W-1] ? IN_W'(-w) : IN_W'(w);
   assign w_zero = (w == '0);
   assign neg = w_zero ? h[IN_W-1] : (h[IN_W-1] != w[IN_W-1]);

   ptsd_div #(.NUM_W(Q_W), .DEN_W(IN_W), .TAG_W(TAG_W + 3)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_valid),
      .num       ({mh, {FRAC_BITS{1'b0}}}),
      .den       (w_zero ? IN_W'(1) : mw),
      .tag_in    ({neg, (mh != '0), w_zero, tag_in}),
      .out_valid (out_valid),
      .quo       (quo),
      .tag_out   (dtag)
   );

   always_comb begin
      if (dtag[TAG_W]) begin
         qe = dtag[TAG_W+1] ? LIM_NEG : '0;
      end else begin
         qe = C_W'(quo);
      end
      if (dtag[TAG_W+2]) begin
         qs = (qe > LIM_NEG) ? LIM_NEG : qe;
         coord = CW'(~qs + C_W'(1));
      end else begin
         qs = (qe > LIM_POS) ? LIM_POS : qe;
         coord = CW'(qs);
      end
   end

   assign tag_out = dtag[TAG_W-1:0];

endmodule

/* src/point_to_segment_distance.sv */
// top level: fixed-point distance from a homogeneous query point to a configured segment
// throughput: one word per cycle; the whole pipeline holds while a result word is stalled
// the depth is set by the bit-per-stage dividers and the square-root stages
// reset: synchronous, clears all valid bits and loads the segment (0,0,1) to (1,0,1)
// no clearing pass; a word may be accepted in the cycle after reset drops
module point_to_segment_distance import ptsd_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [IN_W-1:0] req_query_x,
   input  logic signed [IN_W-1:0] req_query_y,
   input  logic signed [IN_W-1:0] req_query_w,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [OUT_W-1:0]       rsp_distance,
   output logic                   rsp_outside,
   output logic                   rsp_at_infinity,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [IN_W-1:0]        csr_data
);

   localparam int CW = COORD_BITS > 61 ? 61 : (COORD_BITS < 16 ? 16 : COORD_BITS);
   localparam int D_W = CW + 1;
   localparam int E_W = CW + 2;
   localparam int P_W = 2 * CW + 5;
   localparam int R_W = (P_W + 1) / 2;
   localparam int F_W = $bits(flags_type);

   logic signed [IN_W-1:0] start_x_ff, start_y_ff, start_w_ff;
   logic signed [IN_W-1:0] end_x_ff, end_y_ff, end_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         start_w_ff <= IN_W'(65536);
         end_x_ff   <= IN_W'(65536);
         end_y_ff   <= '0;
         end_w_ff   <= IN_W'(65536);
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_START_X: start_x_ff <= csr_data;
            CSR_START_Y: start_y_ff <= csr_data;
            CSR_START_W: start_w_ff <= csr_data;
            CSR_END_X:   end_x_ff   <= csr_data;
            CSR_END_Y:   end_y_ff   <= csr_data;
            CSR_END_W:   end_w_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   logic adv;
   logic rsp_valid_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // dehomogenizing lanes
   logic                 v0;
   logic                 inf0;
   logic                 lane_v [5];
   logic                 lane_t [5];
   logic signed [CW-1:0] px_c, py_c, ax_c, ay_c, bx_c, by_c;

   ptsd_dehom #(.CW(CW), .FRAC_BITS(FRAC_BITS), .TAG_W(1)) u_px (
      .clock(clock), .reset(reset), .en(adv), .in_valid(req_valid),
      .h(req_query_x), .w(req_query_w), .tag_in(req_query_w == '0),
      .out_valid(v0), .coord(px_c), .tag_out(inf0)
   );
   ptsd_dehom #(.CW(CW), .FRAC_BITS(FRAC_BITS), .TAG_W(1)) u_py (
      .clock(clock), .reset(reset), .en(adv), .in_valid(req_valid),
      .h(req_query_y), .w(req_query_w), .tag_in(1'b0),
      .out_valid(lane_v[0]), .coord(py_c), .tag_out(lane_t[0])
   );
   ptsd_dehom #(.CW(CW), .FRAC_BITS(FRAC_BITS), .TAG_W(1)) u_ax (
      .clock(clock), .reset(reset), .en(adv), .in_valid(req_valid),
      .h(start_x_ff), .w(start_w_ff), .tag_in(1'b0),
      .out_valid(lane_v[1]), .coord(ax_c), .tag_out(lane_t[1])
   );
   ptsd_dehom #(.CW(CW), .FRAC_BITS(FRAC_BITS), .TAG_W(1)) u_ay (
      .clock(clock), .reset(reset), .en(adv), .in_valid(req_valid),
      .h(start_y_ff), .w(start_w_ff), .tag_in(1'b0),
      .out_valid(lane_v[2]), .coord(ay_c), .tag_out(lane_t[2])
   );
   ptsd_dehom #(.CW(CW), .FRAC_BITS(FRAC_BITS), .TAG_W(1)) u_bx (
      .clock(clock), .reset(reset), .en(adv), .in_valid(req_valid),
      .h(end_x_ff), .w(end_w_ff), .tag_in(1'b0),
      .out_valid(lane_v[3]), .coord(bx_c), .tag_out(lane_t[3])
   );
   ptsd_dehom #(.CW(CW), .FRAC_BITS(FRAC_BITS), .TAG_W(1)) u_by (
      .clock(clock), .reset(reset), .en(adv), .in_valid(req_valid),
      .h(end_y_ff), .w(end_w_ff), .tag_in(1'b0),
      .out_valid(lane_v[4]), .coord(by_c), .tag_out(lane_t[4])
   );

   // stage 1: plain coordinates
   logic                 v1_ff, inf1_ff;
   logic signed [CW-1:0] px_ff, py_ff, ax_ff, ay_ff, bx_ff, by_ff;
   // stage 2: direction and doubled offset from midpoint
   logic                  v2_ff, inf2_ff;
   logic signed [D_W-1:0] dx_ff, dy_ff;
   logic signed [E_W-1:0] ex_ff, ey_ff;
   // stage 3: products
   logic                  v3_ff, inf3_ff;
   logic signed [P_W-1:0] dxdx_ff, dydy_ff, dxex_ff, dyey_ff, dxey_ff, dyex_ff;
   logic signed [P_W-1:0] exex_ff, eyey_ff;
   // stage 4: sums
   logic                  v4_ff, inf4_ff;
   logic signed [P_W-1:0] s_ff, dot_ff, crs_ff, e2_ff;
   // stage 5: magnitudes and root operand
   logic                  v5_ff, inf5_ff, sz5_ff;
   logic [P_W-1:0]        sq_ff, adot_ff, acrs_ff, s5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         inf1_ff <= inf0;
         px_ff <= px_c;
         py_ff <= py_c;
         ax_ff <= ax_c;
         ay_ff <= ay_c;
         bx_ff <= bx_c;
         by_ff <= by_c;

         inf2_ff <= inf1_ff;
         dx_ff <= D_W'(bx_ff) - D_W'(ax_ff);
         dy_ff <= D_W'(by_ff) - D_W'(ay_ff);
         ex_ff <= (E_W'(px_ff) <<< 1) - E_W'(ax_ff) - E_W'(bx_ff);
         ey_ff <= (E_W'(py_ff) <<< 1) - E_W'(ay_ff) - E_W'(by_ff);

         inf3_ff <= inf2_ff;
         dxdx_ff <= P_W'(dx_ff) * P_W'(dx_ff);
         dydy_ff <= P_W'(dy_ff) * P_W'(dy_ff);
         dxex_ff <= P_W'(dx_ff) * P_W'(ex_ff);
         dyey_ff <= P_W'(dy_ff) * P_W'(ey_ff);
         dxey_ff <= P_W'(dx_ff) * P_W'(ey_ff);
         dyex_ff <= P_W'(dy_ff) * P_W'(ex_ff);
         exex_ff <= P_W'(ex_ff) * P_W'(ex_ff);
         eyey_ff <= P_W'(ey_ff) * P_W'(ey_ff);

         inf4_ff <= inf3_ff;
         s_ff   <= dxdx_ff + dydy_ff;
         dot_ff <= dxex_ff + dyey_ff;
         crs_ff <= dxey_ff - dyex_ff;
         e2_ff  <= exex_ff + eyey_ff;

         inf5_ff <= inf4_ff;
         sz5_ff  <= (s_ff == '0);
         sq_ff   <= (s_ff == '0) ? P_W'(e2_ff) : P_W'(s_ff);
         adot_ff <= dot_ff[P_W-1] ? P_W'(-dot_ff) : P_W'(dot_ff);
         acrs_ff <= crs_ff[P_W-1] ? P_W'(-crs_ff) : P_W'(crs_ff);
         s5_ff   <= P_W'(s_ff);
      end
   end

   // square root of |D|^2, or of |E|^2 for a zero-length segment
   flags_type      flags5;
   flags_type      flags_r;
   logic           v_r;
   logic [R_W-1:0] root;
   logic [F_W+P_W-1:0] tag_r;

   always_comb begin
      flags5.at_inf  = inf5_ff;
      flags5.outside = !inf5_ff && !sz5_ff && (adot_ff > s5_ff);
      flags5.s_zero  = sz5_ff;
   end

   ptsd_sqrt #(.X_W(P_W), .TAG_W(F_W + P_W)) u_sqrt (
      .clock(clock), .reset(reset), .en(adv), .in_valid(v5_ff),
      .x(sq_ff), .tag_in({flags5, acrs_ff}),
      .out_valid(v_r), .root(root), .tag_out(tag_r)
   );

   assign flags_r = flags_type'(tag_r[F_W+P_W-1:P_W]);

   // final divide: |D x E| / (2L), or |E| / 2 for a zero-length segment
   logic           v_q;
   logic [P_W-1:0] quo;
   flags_type      flags_q;
   logic [F_W-1:0] tag_q;

   ptsd_div #(.NUM_W(P_W), .DEN_W(R_W + 1), .TAG_W(F_W)) u_div (
      .clock(clock), .reset(reset), .en(adv), .in_valid(v_r),
      .num(flags_r.s_zero ? P_W'(root) : tag_r[P_W-1:0]),
      .den(flags_r.s_zero ? (R_W+1)'(2) : {root, 1'b0}),
      .tag_in(flags_r),
      .out_valid(v_q), .quo(quo), .tag_out(tag_q)
   );

   assign flags_q = flags_type'(tag_q);

   logic [OUT_W-1:0] dist_ff;
   logic             outside_ff, at_inf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v_q;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         at_inf_ff  <= flags_q.at_inf;
         outside_ff <= flags_q.outside;
         if (flags_q.at_inf || flags_q.outside) begin
            dist_ff <= '0;
         end else if (quo[P_W-1:OUT_W] != '0) begin
            dist_ff <= '1;
         end else begin
            dist_ff <= quo[OUT_W-1:0];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_distance = dist_ff;
   assign rsp_outside = outside_ff;
   assign rsp_at_infinity = at_inf_ff;

`ifndef SYNTH
   a_inf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_at_infinity |-> rsp_distance == '0 && !rsp_outside)
      else $error("query at infinity with nonzero result");
   a_out_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outside |-> rsp_distance == '0)
      else $error("outside result carries a distance");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_distance))
      else $error("stalled result word lost");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall out of step with pipeline hold");
`endif

endmodule

/* bench/tb_point_to_segment_distance.sv */
// testbench: segment distance block checked word by word against a built-in predictor
`timescale 1ns / 100ps

module tb_point_to_segment_distance;
   import ptsd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_B = 3'd7;
   localparam int LATENCY = 158;
   localparam int PHASES = 8;
   localparam int PER_PHASE = 42;
   localparam logic [31:0] ONE = 32'h0001_0000;

   typedef logic signed [127:0] wide_type;

   class distance_board;
      typedef struct {
         logic [31:0] distance;
         logic        beyond;
         logic        at_inf;
      } result_type;

      logic [31:0] seg[6];
      result_type  pending[$];
      int          errors;

      function new();
         seg = '{32'd0, 32'd0, ONE, ONE, 32'd0, ONE};
         errors = 0;
      endfunction

      function void set_reg(int idx, logic [31:0] v);
         if (idx < 6) seg[idx] = v;
      endfunction

      function longint plain(longint h, longint w);
         longint unsigned mh, mw, q;
         bit neg;
         mh = h < 0 ? -h : h;
         mw = w < 0 ? -w : w;
         if (mw == 0) begin
            neg = h < 0;
            q = mh != 0 ? 64'h8000_0000 : 0;
         end else begin
            neg = (h < 0) != (w < 0);
            q = (mh << 16) / mw;
         end
         if (neg) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return -longint'(q);
         end
         if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
         return longint'(q);
      endfunction

      function logic [63:0] root(logic [127:0] x);
         logic [63:0]  r, t;
         logic [127:0] tt;
         r = 0;
         for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            tt = t;
            if (tt * tt <= x) r = t;
         end
         return r;
      endfunction

      function void note_query(logic [31:0] qx, logic [31:0] qy, logic [31:0] qw);
         result_type   res;
         longint       px, py, ax, ay, bx, by;
         wide_type     dx, dy, ex, ey, len2, dot, crs;
         logic [63:0]  len;
         logic [127:0] quo;
         res = '{32'd0, 1'b0, 1'b0};
         if (qw == 0) begin
            res.at_inf = 1'b1;
         end else begin
            px = plain(longint'($signed(qx)), longint'($signed(qw)));
            py = plain(longint'($signed(qy)), longint'($signed(qw)));
            ax = plain(longint'($signed(seg[0])), longint'($signed(seg[2])));
            ay = plain(longint'($signed(seg[1])), longint'($signed(seg[2])));
            bx = plain(longint'($signed(seg[3])), longint'($signed(seg[5])));
            by = plain(longint'($signed(seg[4])), longint'($signed(seg[5])));
            dx = bx - ax;
            dy = by - ay;
            ex = 2 * px - ax - bx;
            ey = 2 * py - ay - by;
            len2 = dx * dx + dy * dy;
            if (len2 == 0) begin
               quo = root(ex * ex + ey * ey) >> 1;
               res.distance = quo > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : quo[31:0];
            end else begin
               dot = dx * ex + dy * ey;
               if (dot < 0) dot = -dot;
               if (dot > len2) begin
                  res.beyond = 1'b1;
               end else begin
                  crs = dx * ey - dy * ex;
                  if (crs < 0) crs = -crs;
                  len = root(len2);
                  quo = 128'(crs) / ({64'd0, len} << 1);
                  res.distance = quo > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : quo[31:0];
               end
            end
         end
         pending.push_back(res);
      endfunction

      task report(string msg);
         $display("error at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(logic [31:0] distance, logic beyond, logic at_inf);
         result_type exp_res;
         if (pending.size() == 0) begin
            report("result word with none expected");
            return;
         end
         exp_res = pending.pop_front();
         if (distance !== exp_res.distance)
            report($sformatf("distance %h, expected %h", distance, exp_res.distance));
         if (beyond !== exp_res.beyond)
            report($sformatf("outside %b, expected %b", beyond, exp_res.beyond));
         if (at_inf !== exp_res.at_inf)
            report($sformatf("at_infinity %b, expected %b", at_inf, exp_res.at_inf));
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic signed [IN_W-1:0] req_query_x;
   logic signed [IN_W-1:0] req_query_y;
   logic signed [IN_W-1:0] req_query_w;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [OUT_W-1:0]       rsp_distance;
   logic                   rsp_outside;
   logic                   rsp_at_infinity;
   logic                   csr_wr_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [IN_W-1:0]        csr_data;

   distance_board board = new();
   bit no_idle;
   int hold_left;

   point_to_segment_distance dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_query_x(req_query_x), .req_query_y(req_query_y), .req_query_w(req_query_w),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_distance(rsp_distance), .rsp_outside(rsp_outside),
      .rsp_at_infinity(rsp_at_infinity),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("point_to_segment_distance: mismatch");
      $finish;
   end

   // result side: random stall per word unless no_idle is set, plus one long hold in phase 2
   initial begin
      int wait_left;
      wait_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            board.check_result(rsp_distance, rsp_outside, rsp_at_infinity);
            wait_left = no_idle ? 0 : $urandom_range(0, 12);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task send_query(logic [31:0] qx, logic [31:0] qy, logic [31:0] qw);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_query_x <= qx;
      req_query_y <= qy;
      req_query_w <= qw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_query(qx, qy, qw);
   endtask

   task write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      board.set_reg(int'(idx), v);
   endtask

   task wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function logic [31:0] coord(int span);
      return 32'($urandom_range(0, 2 * span) - span);
   endfunction

   task send_random();
      logic [31:0] qx, qy, qw;
      case ($urandom_range(0, 9))
         0: begin
            qx = $urandom; qy = $urandom; qw = $urandom;
         end
         1: begin
            qx = $urandom; qy = $urandom; qw = 32'd0;
         end
         2: begin
            qx = coord(32'h0064_0000); qy = coord(32'h0064_0000);
            qw = coord(32'h0004_0000);
         end
         3: begin
            qx = $urandom; qy = $urandom; qw = coord(8);
         end
         default: begin
            qx = coord(32'h0032_0000); qy = coord(32'h0032_0000);
            qw = $urandom_range(0, 1) ? ONE : -ONE;
         end
      endcase
      send_query(qx, qy, qw);
   endtask

   logic [31:0] segs[PHASES][6];

   initial begin
      segs[0] = '{32'd0, 32'd0, ONE, ONE, 32'd0, ONE};
      segs[1] = '{-32'sh000A_0000, -32'sh0005_0000, ONE, 32'h0014_0000, 32'h000F_0000, ONE};
      segs[2] = '{32'h0003_0000, 32'h0004_0000, ONE, 32'h0006_0000, 32'h0008_0000, 32'h0002_0000};
      segs[3] = '{32'h7FFF_FFFF, 32'h8000_0000, ONE, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF};
      segs[4] = '{32'h0005_0000, 32'd0, 32'd0, 32'd0, 32'd0, ONE};
      segs[5] = '{-32'sh0004_0000, 32'h0002_0000, -ONE, 32'h0003_0000, ONE, -32'sh0002_0000};
      segs[6] = '{32'd3, -32'sd2, 32'd1, -32'sd5, 32'd7, 32'hFFFF_FFFF};
      segs[7] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000};

      reset = 1'b1;
      req_valid = 1'b0;
      req_query_x = '0;
      req_query_y = '0;
      req_query_w = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      no_idle = 1'b0;
      hold_left = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // edge cases on the reset segment from (0,0) to (1,0)
      send_query(32'd0, 32'd0, 32'd0);
      send_query(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
      send_query(32'd0, 32'd0, ONE);
      send_query(ONE, 32'd0, ONE);
      send_query(32'h0000_8000, 32'h0003_0000, ONE);
      send_query(32'h0000_8000, -32'sh0003_0000, ONE);
      send_query(32'h0002_0000, 32'h0001_0000, ONE);
      send_query(-32'sh0001_0000, 32'd0, ONE);
      send_query(32'h0001_0001, 32'd0, ONE);
      send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_query(32'h0000_8000, 32'h7FFF_FFFF, 32'd1);
      send_query(32'h0000_8000, 32'h8000_0000, 32'hFFFF_FFFF);
      send_query(32'h0000_4000, 32'h0000_2000, -ONE);
      send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_query(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0100);
      send_query(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000);
      send_query(32'h0000_8000, 32'h0000_0001, ONE);

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         if (p > 0) begin
            for (int r = 0; r < 6; r++) write_reg(CSR_IDX_W'(r), segs[p][r]);
            if (p == 3) begin
               write_reg(CSR_UNUSED_A, $urandom);
               write_reg(CSR_UNUSED_B, $urandom);
            end
         end
         no_idle = (p == 1 || p == 6);
         if (p == 2) begin
            hold_left = 3 * LATENCY;
            no_idle = 1'b1;
         end
         for (int i = 0; i < PER_PHASE; i++) begin
            if (p == 2 && i == 20) no_idle = 1'b0;
            send_random();
         end
      end
      // corner segment endpoints on the last phase, then random endpoints
      wait_idle();
      write_reg(CSR_START_X, $urandom);
      write_reg(CSR_START_Y, $urandom);
      write_reg(CSR_START_W, $urandom);
      write_reg(CSR_END_X, $urandom);
      write_reg(CSR_END_Y, $urandom);
      write_reg(CSR_END_W, $urandom);
      for (int i = 0; i < PER_PHASE; i++) send_random();
      wait_idle();

      if (board.errors == 0 && board.pending.size() == 0)
         $display("point_to_segment_distance: match");
      else
         $display("point_to_segment_distance: mismatch");
      $finish;
   end

endmodule
